FILE: hw/rtl/ps2mpt_pkg.sv
package ps2mpt_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int DELTA_WIDTH    = 12;
   localparam int RAW_WIDTH      = 10;
   localparam int BUTTON_WIDTH   = 3;
   localparam int POS_OUT_WIDTH  = 16;
   localparam int WHEEL_OUT_WIDTH = 32;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam int X_SIGN_BIT  = 4;
   localparam int Y_SIGN_BIT  = 5;
   localparam int BOOST_LIMIT = 5;
   localparam int BOOST_SHIFT = 2;

   localparam int X_LOWER_RESET  = 0;
   localparam int X_UPPER_RESET  = 320;
   localparam int Y_LOWER_RESET  = 0;
   localparam int Y_UPPER_RESET  = 200;
   localparam int CURSOR_X_RESET = 160;
   localparam int CURSOR_Y_RESET = 100;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_WHEEL_MODE = 3'd0,
      CSR_X_LOWER    = 3'd1,
      CSR_X_UPPER    = 3'd2,
      CSR_Y_LOWER    = 3'd3,
      CSR_Y_UPPER    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2,
      POS_WHEEL  = 2'd3
   } byte_pos_type;

   typedef struct packed {
      logic       valid;
      logic       error;
      logic [7:0] data;
   } rx_item_type;

endpackage

FILE: hw/rtl/ps2mpt_csr.sv
module ps2mpt_csr
   import ps2mpt_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [COORD_WIDTH-1:0]        csr_wdata,
   output logic                          wheel_mode,
   output logic signed [COORD_WIDTH-1:0] x_lower,
   output logic signed [COORD_WIDTH-1:0] x_upper,
   output logic signed [COORD_WIDTH-1:0] y_lower,
   output logic signed [COORD_WIDTH-1:0] y_upper
);

   logic                   wheel_mode_ff, wheel_mode_in;
   logic [COORD_WIDTH-1:0] x_lower_ff, x_lower_in;
   logic [COORD_WIDTH-1:0] x_upper_ff, x_upper_in;
   logic [COORD_WIDTH-1:0] y_lower_ff, y_lower_in;
   logic [COORD_WIDTH-1:0] y_upper_ff, y_upper_in;

   always_comb begin
      wheel_mode_in = wheel_mode_ff;
      x_lower_in    = x_lower_ff;
      x_upper_in    = x_upper_ff;
      y_lower_in    = y_lower_ff;
      y_upper_in    = y_upper_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_WHEEL_MODE: wheel_mode_in = csr_wdata[0];
            CSR_X_LOWER:    x_lower_in    = csr_wdata;
            CSR_X_UPPER:    x_upper_in    = csr_wdata;
            CSR_Y_LOWER:    y_lower_in    = csr_wdata;
            CSR_Y_UPPER:    y_upper_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_mode_ff <= 1'b0;
         x_lower_ff    <= COORD_WIDTH'(X_LOWER_RESET);
         x_upper_ff    <= COORD_WIDTH'(X_UPPER_RESET);
         y_lower_ff    <= COORD_WIDTH'(Y_LOWER_RESET);
         y_upper_ff    <= COORD_WIDTH'(Y_UPPER_RESET);
      end else begin
         wheel_mode_ff <= wheel_mode_in;
         x_lower_ff    <= x_lower_in;
         x_upper_ff    <= x_upper_in;
         y_lower_ff    <= y_lower_in;
         y_upper_ff    <= y_upper_in;
      end
   end

   assign wheel_mode = wheel_mode_ff;
   assign x_lower    = $signed(x_lower_ff);
   assign x_upper    = $signed(x_upper_ff);
   assign y_lower    = $signed(y_lower_ff);
   assign y_upper    = $signed(y_upper_ff);

endmodule

FILE: hw/rtl/ps2mpt_core.sv
module ps2mpt_core
   import ps2mpt_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int WHEEL_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  rx_item_type                   item,
   input  logic                          wheel_mode,
   input  logic signed [COORD_WIDTH-1:0] x_lower,
   input  logic signed [COORD_WIDTH-1:0] x_upper,
   input  logic signed [COORD_WIDTH-1:0] y_lower,
   input  logic signed [COORD_WIDTH-1:0] y_upper,
   output logic                          done,
   output logic signed [COORD_WIDTH-1:0] pos_x,
   output logic signed [COORD_WIDTH-1:0] pos_y,
   output logic [BUTTON_WIDTH-1:0]       buttons,
   output logic signed [WHEEL_WIDTH-1:0] wheel_sum
);

   localparam int SUM_WIDTH = COORD_WIDTH + 2;

   byte_pos_type pos_ff, pos_in;
   logic [7:0]   first_ff, second_ff, third_ff;
   logic signed [COORD_WIDTH-1:0] cursor_x_ff, cursor_x_in;
   logic signed [COORD_WIDTH-1:0] cursor_y_ff, cursor_y_in;
   logic signed [WHEEL_WIDTH-1:0] wheel_ff, wheel_in;

   logic take, load_first, load_second, load_third;
   logic [7:0] third_sel, wheel_sel;
   logic signed [RAW_WIDTH-1:0]   dx_raw, dy_raw;
   logic signed [DELTA_WIDTH-1:0] dx, dy;
   logic signed [SUM_WIDTH-1:0]   sum_x, sum_y;

   function automatic logic signed [DELTA_WIDTH-1:0] boost(
      input logic signed [RAW_WIDTH-1:0] d
   );
      logic signed [DELTA_WIDTH-1:0] ext;
      logic signed [RAW_WIDTH-1:0]   lim;
      ext = DELTA_WIDTH'(d);
      lim = RAW_WIDTH'(BOOST_LIMIT);
      if (d > lim || d < -lim) begin
         return ext <<< BOOST_SHIFT;
      end
      return ext;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] clamp(
      input logic signed [SUM_WIDTH-1:0]   v,
      input logic signed [COORD_WIDTH-1:0] lo,
      input logic signed [COORD_WIDTH-1:0] hi
   );
      logic signed [SUM_WIDTH-1:0] lo_ext, hi_ext, t;
      lo_ext = SUM_WIDTH'(lo);
      hi_ext = SUM_WIDTH'(hi);
      t = (v > hi_ext) ? hi_ext : v;
      if (t < lo_ext) begin
         t = lo_ext;
      end
      return t[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      pos_in = pos_ff;
      if (step && !item.error) begin
         case (pos_ff)
            POS_FIRST:  pos_in = (item.data != SYNC_BYTE) ? POS_SECOND : POS_FIRST;
            POS_SECOND: pos_in = POS_THIRD;
            POS_THIRD:  pos_in = wheel_mode ? POS_WHEEL : POS_FIRST;
            POS_WHEEL:  pos_in = POS_FIRST;
            default:    pos_in = POS_FIRST;
         endcase
      end
   end

   always_comb begin
      take        = step && !item.error;
      load_first  = 1'b0;
      load_second = 1'b0;
      load_third  = 1'b0;
      done        = 1'b0;
      case (pos_ff)
         POS_FIRST:  load_first  = take && (item.data != SYNC_BYTE);
         POS_SECOND: load_second = take;
         POS_THIRD: begin
            load_third = take;
            done       = take && !wheel_mode;
         end
         POS_WHEEL:  done = take;
         default: begin
         end
      endcase
   end

   always_comb begin
      third_sel = (pos_ff == POS_THIRD) ? item.data : third_ff;
      wheel_sel = (pos_ff == POS_WHEEL) ? item.data : 8'h00;
      dx_raw = RAW_WIDTH'($signed({first_ff[X_SIGN_BIT], second_ff}));
      dy_raw = -RAW_WIDTH'($signed({first_ff[Y_SIGN_BIT], third_sel}));
      dx = boost(dx_raw);
      dy = boost(dy_raw);
      sum_x = SUM_WIDTH'(cursor_x_ff) + SUM_WIDTH'(dx);
      sum_y = SUM_WIDTH'(cursor_y_ff) + SUM_WIDTH'(dy);
      cursor_x_in = clamp(sum_x, x_lower, x_upper);
      cursor_y_in = clamp(sum_y, y_lower, y_upper);
      wheel_in = wheel_ff + WHEEL_WIDTH'($signed(wheel_sel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_FIRST;
         cursor_x_ff <= COORD_WIDTH'(CURSOR_X_RESET);
         cursor_y_ff <= COORD_WIDTH'(CURSOR_Y_RESET);
         wheel_ff    <= '0;
      end else begin
         pos_ff <= pos_in;
         if (done) begin
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
            wheel_ff    <= wheel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_first) begin
         first_ff <= item.data;
      end
      if (load_second) begin
         second_ff <= item.data;
      end
      if (load_third) begin
         third_ff <= item.data;
      end
   end

   assign pos_x     = cursor_x_in;
   assign pos_y     = cursor_y_in;
   assign buttons   = {first_ff[0], first_ff[2], first_ff[1]};
   assign wheel_sum = wheel_in;

`ifndef SYNTH
   a_done_needs_good_byte: assert property (@(posedge clock) disable iff (reset)
      done |-> step && !item.error)
      else $error("packet completed without an accepted good byte");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      done |=> pos_ff == POS_FIRST)
      else $error("byte position did not return to the first byte after a packet");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      step && item.error |=> $stable(pos_ff) && $stable(cursor_x_ff) && $stable(wheel_ff))
      else $error("a byte with an error changed the tracker state");

   a_sync_dropped: assert property (@(posedge clock) disable iff (reset)
      step && pos_ff == POS_FIRST && item.data == SYNC_BYTE |=> pos_ff == POS_FIRST)
      else $error("a leading 0xFF byte was taken into a packet");

   a_x_in_box: assert property (@(posedge clock) disable iff (reset)
      done && x_lower <= x_upper |-> cursor_x_in >= x_lower && cursor_x_in <= x_upper)
      else $error("horizontal position left the configured box");
`endif

endmodule

FILE: hw/rtl/ps2_mouse_packet_tracker_unit.sv
// A result is registered as the byte completing its packet leaves the input register.
// Throughput: one byte per cycle while results are taken; a result that waits holds the
// byte in the input register, so at most one more transaction is taken until it leaves.
// Reset is synchronous and active high; it clears the byte position, the wheel total,
// restores the position to 160, 100 and the box registers to their reset values.
module ps2_mouse_packet_tracker_unit
   import ps2mpt_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int WHEEL_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   input  logic                              req_rx_error,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [POS_OUT_WIDTH-1:0]   rsp_pos_x,
   output logic signed [POS_OUT_WIDTH-1:0]   rsp_pos_y,
   output logic [BUTTON_WIDTH-1:0]           rsp_button_bits,
   output logic signed [WHEEL_OUT_WIDTH-1:0] rsp_wheel_total,
   input  logic                              csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]         csr_addr,
   input  logic [COORD_WIDTH-1:0]            csr_wdata
);

   rx_item_type rx_ff, rx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [POS_OUT_WIDTH-1:0]   pos_x_ff, pos_y_ff;
   logic [BUTTON_WIDTH-1:0]           buttons_ff;
   logic signed [WHEEL_OUT_WIDTH-1:0] wheel_total_ff;

   logic advance, done, wheel_mode;
   logic signed [COORD_WIDTH-1:0] x_lower, x_upper, y_lower, y_upper;
   logic signed [COORD_WIDTH-1:0] pos_x, pos_y;
   logic [BUTTON_WIDTH-1:0]       buttons;
   logic signed [WHEEL_WIDTH-1:0] wheel_sum;
   logic [31:0] pos_x_wide, pos_y_wide;
   logic [63:0] wheel_wide;

   ps2mpt_csr #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .wheel_mode(wheel_mode),
      .x_lower(x_lower),
      .x_upper(x_upper),
      .y_lower(y_lower),
      .y_upper(y_upper)
   );

   ps2mpt_core #(
      .COORD_WIDTH(COORD_WIDTH),
      .WHEEL_WIDTH(WHEEL_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .item(rx_ff),
      .wheel_mode(wheel_mode),
      .x_lower(x_lower),
      .x_upper(x_upper),
      .y_lower(y_lower),
      .y_upper(y_upper),
      .done(done),
      .pos_x(pos_x),
      .pos_y(pos_y),
      .buttons(buttons),
      .wheel_sum(wheel_sum)
   );

   assign advance   = rx_ff.valid && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !rx_ff.valid || advance;

   always_comb begin
      rx_in = rx_ff;
      if (req_valid && req_ready) begin
         rx_in.valid = 1'b1;
         rx_in.error = req_rx_error;
         rx_in.data  = req_rx_byte;
      end else if (advance) begin
         rx_in.valid = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign pos_x_wide = 32'(pos_x);
   assign pos_y_wide = 32'(pos_y);
   assign wheel_wide = 64'(wheel_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_ff        <= rx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && done) begin
         pos_x_ff       <= pos_x_wide[POS_OUT_WIDTH-1:0];
         pos_y_ff       <= pos_y_wide[POS_OUT_WIDTH-1:0];
         buttons_ff     <= buttons;
         wheel_total_ff <= wheel_wide[WHEEL_OUT_WIDTH-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_button_bits = buttons_ff;
   assign rsp_wheel_total = wheel_total_ff;

`ifndef SYNTH
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(advance && done))
      else $error("a waiting result was overwritten");

   a_input_not_lost: assert property (@(posedge clock) disable iff (reset)
      rx_ff.valid && !advance |=> rx_ff.valid)
      else $error("a held input transaction was dropped");

   a_result_follows_packet: assert property (@(posedge clock) disable iff (reset)
      advance && done |=> rsp_valid_ff)
      else $error("a completed packet produced no result");
`endif

endmodule
